// ===== rtl/triangle_circumcenter_3d_top_defines.svh =====
// ----------------------------------------------------------------------------
// Triangle circumcentre: assertion macros
// Shared property forms, clocked on clk and switched off while rst is high.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_CIRCUMCENTER_3D_TOP_DEFINES_SVH
`define TRIANGLE_CIRCUMCENTER_3D_TOP_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define TCC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define TCC_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle circumcentre: package
// Item types, datapath widths and configuration register indexes.
// ----------------------------------------------------------------------------
package tcc_pkg;

  localparam int COORD_W  = 32;
  localparam int NORM_W   = 16;
  localparam int CHUNK_W  = 32;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int SQ_W     = 2 * COORD_W;
  localparam int SUMSQ_W  = SQ_W + 2;
  localparam int NB_W     = NORM_W + COORD_W;
  localparam int SUMNB_W  = NB_W + 2;
  localparam int RHS_W    = 2 * COORD_W + 3;
  localparam int XP_W     = 2 * DIFF_W + 1;
  localparam int DET_W    = DIFF_W + XP_W + 2;
  localparam int NUM_W    = RHS_W + XP_W + 2;
  localparam int DIV_W    = NUM_W + 1;
  localparam int QUO_W    = COORD_W + 1;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Z = 2'd2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [NORM_W-1:0]  norm_t;

  localparam norm_t NORMAL_Z_RESET = 16'sd16384;

  typedef struct packed {
    coord_t point_a_x;
    coord_t point_a_y;
    coord_t point_a_z;
    coord_t point_b_x;
    coord_t point_b_y;
    coord_t point_b_z;
    coord_t point_c_x;
    coord_t point_c_y;
    coord_t point_c_z;
  } points_t;

  typedef struct packed {
    coord_t center_x;
    coord_t center_y;
    coord_t center_z;
    logic   degenerate;
  } center_t;

endpackage

// ===== rtl/tcc_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle circumcentre: pipelined signed multiplier
// Splits both operands into word-sized chunks, registers the partial
// products, then adds them up and registers the sum.
// ----------------------------------------------------------------------------
module tcc_mul #(
  parameter int A_W = 33,
  parameter int B_W = 16
) (
  input  logic                    clk,
  input  logic signed [A_W-1:0]   a,
  input  logic signed [B_W-1:0]   b,
  output logic signed [A_W+B_W-1:0] p
);
  import tcc_pkg::*;

  localparam int NA    = (A_W + CHUNK_W - 1) / CHUNK_W;
  localparam int NB    = (B_W + CHUNK_W - 1) / CHUNK_W;
  localparam int EA    = NA * CHUNK_W;
  localparam int EB    = NB * CHUNK_W;
  localparam int PP_W  = 2 * (CHUNK_W + 1);
  localparam int SUM_W = EA + EB;

  logic signed [EA-1:0]    a_ext;
  logic signed [EB-1:0]    b_ext;
  logic signed [PP_W-1:0]  pp [NA][NB];
  logic signed [SUM_W-1:0] sum;

  assign a_ext = EA'(a);
  assign b_ext = EB'(b);

  for (genvar i = 0; i < NA; i++) begin : g_a
    for (genvar j = 0; j < NB; j++) begin : g_b
      logic signed [CHUNK_W:0] ca;
      logic signed [CHUNK_W:0] cb;
      if (i == NA - 1) begin : g_atop
        assign ca = {a_ext[EA-1], a_ext[i*CHUNK_W +: CHUNK_W]};
      end else begin : g_alow
        assign ca = {1'b0, a_ext[i*CHUNK_W +: CHUNK_W]};
      end
      if (j == NB - 1) begin : g_btop
        assign cb = {b_ext[EB-1], b_ext[j*CHUNK_W +: CHUNK_W]};
      end else begin : g_blow
        assign cb = {1'b0, b_ext[j*CHUNK_W +: CHUNK_W]};
      end
      always_ff @(posedge clk) begin
        pp[i][j] <= PP_W'(ca) * PP_W'(cb);
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        sum = sum + (SUM_W'(pp[i][j]) <<< (CHUNK_W * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    p <= sum[A_W+B_W-1:0];
  end

endmodule

// ===== rtl/tcc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle circumcentre: pipelined restoring divider
// One quotient bit per stage, preceded by a stage that flags quotients too
// large for the quotient width.
// ----------------------------------------------------------------------------
module tcc_div #(
  parameter int D_W = 137,
  parameter int Q_W = 33
) (
  input  logic           clk,
  input  logic [D_W-1:0] dividend,
  input  logic [D_W-1:0] divisor,
  output logic [Q_W-1:0] quotient,
  output logic           overflow
);
  localparam int W = D_W + Q_W;

  logic [D_W-1:0] rem [Q_W+1];
  logic [D_W-1:0] dvs [Q_W+1];
  logic [Q_W-1:0] quo [Q_W+1];
  logic           ovf [Q_W+1];

  always_ff @(posedge clk) begin
    rem[0] <= dividend;
    dvs[0] <= divisor;
    quo[0] <= '0;
    ovf[0] <= W'(dividend) >= {divisor, {Q_W{1'b0}}};
  end

  for (genvar s = 1; s <= Q_W; s++) begin : g_stage
    localparam int J = Q_W - s;
    logic [W-1:0] trial;
    logic         take;

    assign trial = W'(dvs[s-1]) << J;
    assign take  = W'(rem[s-1]) >= trial;

    always_ff @(posedge clk) begin
      rem[s] <= take ? D_W'(W'(rem[s-1]) - trial) : rem[s-1];
      dvs[s] <= dvs[s-1];
      ovf[s] <= ovf[s-1];
      quo[s] <= quo[s-1] | (Q_W'(take) << J);
    end
  end

  assign quotient = quo[Q_W];
  assign overflow = ovf[Q_W];

endmodule

// ===== rtl/triangle_circumcenter_3d_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle circumcentre, top level
// Solves the bisector-plane system of a triangle by Cramer's rule in exact
// wide integer arithmetic and rounds and saturates the final quotients.
//
//   channel   handshake            payload
//   -------   ------------------   ------------------------------
//   input     start / busy         points (points_t)
//   result    done (strobe)        center (center_t)
//   config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item is taken in every cycle; busy stays low.
// Each result comes from the divider behind the two multiplier groups.
// Reset clears the valid line and loads the default normal (0, 0, 1.0).
// The result side cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
`include "triangle_circumcenter_3d_top_defines.svh"

module triangle_circumcenter_3d_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  tcc_pkg::points_t          points,
  output logic                      done,
  output tcc_pkg::center_t          center,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [tcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  tcc_pkg::norm_t            cfg_data
);
  import tcc_pkg::*;

  localparam int LAT = 13 + QUO_W;
  localparam coord_t CoordMax = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t CoordMin = {1'b1, {(COORD_W-1){1'b0}}};

  norm_t nrm [3];
  logic [LAT-1:0] vld;

  coord_t a1 [3], b1 [3], c1 [3];
  coord_t a2 [3], b2 [3], c2 [3];
  logic signed [DIFF_W-1:0] m0_2 [3], m1_2 [3];
  logic signed [DIFF_W-1:0] m0_d [4][3];

  logic signed [SQ_W-1:0] sq_a [3], sq_b [3], sq_c [3];
  logic signed [NB_W-1:0] nb_p [3];
  logic signed [DIFF_W+NORM_W-1:0] xp_1 [3], xp_2 [3], xq_1 [3], xq_2 [3];
  logic signed [2*DIFF_W-1:0] xs_1 [3], xs_2 [3];

  logic signed [SUMSQ_W-1:0] sa5, sb5, sc5;
  logic signed [SUMNB_W-1:0] nb5;
  logic signed [XP_W-1:0] xp5 [3], xq5 [3], xs5 [3];
  logic signed [XP_W-1:0] xp6 [3], xq6 [3], xs6 [3];
  logic signed [RHS_W-1:0] r0_6, r1_6, r2_6;

  logic signed [DIFF_W+XP_W-1:0] dt8 [3];
  logic signed [RHS_W+XP_W-1:0] n0_8 [3], n1_8 [3], n2_8 [3];

  logic signed [DET_W-1:0] det9;
  logic signed [NUM_W-1:0] num9 [3];
  logic [DET_W-1:0] adet10;
  logic [NUM_W-1:0] anum10 [3];
  logic [2:0] neg10;
  logic deg10;
  logic [DIV_W-1:0] dvd11 [3];
  logic [DIV_W-1:0] dvs11;
  logic [2:0] neg11;
  logic deg11;
  logic [2:0] neg_d [QUO_W+1];
  logic deg_d [QUO_W+1];
  logic [QUO_W-1:0] quo [3];
  logic ovf [3];
  center_t center_next;

  function automatic coord_t fit(input logic [QUO_W-1:0] q, input logic of,
                                 input logic ng);
    logic [QUO_W-1:0] lim;
    logic [QUO_W-1:0] nq;
    coord_t res;
    lim = QUO_W'(1) << (COORD_W - 1);
    nq = -q;
    if (ng) begin
      res = (of || q > lim) ? CoordMin : nq[COORD_W-1:0];
    end else begin
      res = (of || q >= lim) ? CoordMax : q[COORD_W-1:0];
    end
    return res;
  endfunction

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;
  assign done = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      nrm[0] <= '0;
      nrm[1] <= '0;
      nrm[2] <= NORMAL_Z_RESET;
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start && !busy};
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_NORMAL_X: nrm[0] <= cfg_data;
          CFG_NORMAL_Y: nrm[1] <= cfg_data;
          CFG_NORMAL_Z: nrm[2] <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    a1[0] <= points.point_a_x;
    a1[1] <= points.point_a_y;
    a1[2] <= points.point_a_z;
    b1[0] <= points.point_b_x;
    b1[1] <= points.point_b_y;
    b1[2] <= points.point_b_z;
    c1[0] <= points.point_c_x;
    c1[1] <= points.point_c_y;
    c1[2] <= points.point_c_z;
    for (int k = 0; k < 3; k++) begin
      a2[k] <= a1[k];
      b2[k] <= b1[k];
      c2[k] <= c1[k];
      m0_2[k] <= DIFF_W'(b1[k]) - DIFF_W'(a1[k]);
      m1_2[k] <= DIFF_W'(c1[k]) - DIFF_W'(a1[k]);
      m0_d[0][k] <= m0_2[k];
      m0_d[1][k] <= m0_d[0][k];
      m0_d[2][k] <= m0_d[1][k];
      m0_d[3][k] <= m0_d[2][k];
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_mul1
    localparam int K1 = (k + 1) % 3;
    localparam int K2 = (k + 2) % 3;
    tcc_mul #(.A_W(COORD_W), .B_W(COORD_W)) u_sqa (.clk, .a(a2[k]), .b(a2[k]), .p(sq_a[k]));
    tcc_mul #(.A_W(COORD_W), .B_W(COORD_W)) u_sqb (.clk, .a(b2[k]), .b(b2[k]), .p(sq_b[k]));
    tcc_mul #(.A_W(COORD_W), .B_W(COORD_W)) u_sqc (.clk, .a(c2[k]), .b(c2[k]), .p(sq_c[k]));
    tcc_mul #(.A_W(COORD_W), .B_W(NORM_W)) u_nb (.clk, .a(b2[k]), .b(nrm[k]), .p(nb_p[k]));
    tcc_mul #(.A_W(DIFF_W), .B_W(NORM_W)) u_xp1 (.clk, .a(m1_2[K1]), .b(nrm[K2]),
                                               .p(xp_1[k]));
    tcc_mul #(.A_W(DIFF_W), .B_W(NORM_W)) u_xp2 (.clk, .a(m1_2[K2]), .b(nrm[K1]),
                                               .p(xp_2[k]));
    tcc_mul #(.A_W(DIFF_W), .B_W(NORM_W)) u_xq1 (.clk, .a(m0_2[K2]), .b(nrm[K1]),
                                               .p(xq_1[k]));
    tcc_mul #(.A_W(DIFF_W), .B_W(NORM_W)) u_xq2 (.clk, .a(m0_2[K1]), .b(nrm[K2]),
                                               .p(xq_2[k]));
    tcc_mul #(.A_W(DIFF_W), .B_W(DIFF_W)) u_xs1 (.clk, .a(m0_2[K1]), .b(m1_2[K2]),
                                               .p(xs_1[k]));
    tcc_mul #(.A_W(DIFF_W), .B_W(DIFF_W)) u_xs2 (.clk, .a(m0_2[K2]), .b(m1_2[K1]),
                                               .p(xs_2[k]));
  end

  always_ff @(posedge clk) begin
    sa5 <= SUMSQ_W'(sq_a[0]) + SUMSQ_W'(sq_a[1]) + SUMSQ_W'(sq_a[2]);
    sb5 <= SUMSQ_W'(sq_b[0]) + SUMSQ_W'(sq_b[1]) + SUMSQ_W'(sq_b[2]);
    sc5 <= SUMSQ_W'(sq_c[0]) + SUMSQ_W'(sq_c[1]) + SUMSQ_W'(sq_c[2]);
    nb5 <= SUMNB_W'(nb_p[0]) + SUMNB_W'(nb_p[1]) + SUMNB_W'(nb_p[2]);
    for (int k = 0; k < 3; k++) begin
      xp5[k] <= XP_W'(xp_1[k]) - XP_W'(xp_2[k]);
      xq5[k] <= XP_W'(xq_1[k]) - XP_W'(xq_2[k]);
      xs5[k] <= XP_W'(xs_1[k]) - XP_W'(xs_2[k]);
      xp6[k] <= xp5[k];
      xq6[k] <= xq5[k];
      xs6[k] <= xs5[k];
    end
    r0_6 <= RHS_W'(sb5) - RHS_W'(sa5);
    r1_6 <= RHS_W'(sc5) - RHS_W'(sa5);
    r2_6 <= RHS_W'(nb5) + RHS_W'(nb5);
  end

  for (genvar k = 0; k < 3; k++) begin : g_mul2
    tcc_mul #(.A_W(DIFF_W), .B_W(XP_W)) u_det (.clk, .a(m0_d[3][k]), .b(xp6[k]),
                                             .p(dt8[k]));
    tcc_mul #(.A_W(RHS_W), .B_W(XP_W)) u_n0 (.clk, .a(r0_6), .b(xp6[k]), .p(n0_8[k]));
    tcc_mul #(.A_W(RHS_W), .B_W(XP_W)) u_n1 (.clk, .a(r1_6), .b(xq6[k]), .p(n1_8[k]));
    tcc_mul #(.A_W(RHS_W), .B_W(XP_W)) u_n2 (.clk, .a(r2_6), .b(xs6[k]), .p(n2_8[k]));
  end

  always_ff @(posedge clk) begin
    det9 <= DET_W'(dt8[0]) + DET_W'(dt8[1]) + DET_W'(dt8[2]);
    adet10 <= det9[DET_W-1] ? DET_W'(-det9) : DET_W'(det9);
    deg10 <= det9 == '0;
    dvs11 <= DIV_W'(adet10) + DIV_W'(adet10);
    neg11 <= neg10;
    deg11 <= deg10;
    for (int k = 0; k < 3; k++) begin
      num9[k] <= NUM_W'(n0_8[k]) + NUM_W'(n1_8[k]) + NUM_W'(n2_8[k]);
      anum10[k] <= num9[k][NUM_W-1] ? NUM_W'(-num9[k]) : NUM_W'(num9[k]);
      neg10[k] <= num9[k][NUM_W-1] != det9[DET_W-1];
      dvd11[k] <= DIV_W'(anum10[k]) + DIV_W'(adet10);
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_div
    tcc_div #(.D_W(DIV_W), .Q_W(QUO_W)) u_div (
      .clk,
      .dividend(dvd11[k]),
      .divisor (dvs11),
      .quotient(quo[k]),
      .overflow(ovf[k])
    );
  end

  always_ff @(posedge clk) begin
    neg_d[0] <= neg11;
    deg_d[0] <= deg11;
    for (int s = 1; s <= QUO_W; s++) begin
      neg_d[s] <= neg_d[s-1];
      deg_d[s] <= deg_d[s-1];
    end
  end

  always_comb begin
    center_next.center_x   = fit(quo[0], ovf[0], neg_d[QUO_W][0]);
    center_next.center_y   = fit(quo[1], ovf[1], neg_d[QUO_W][1]);
    center_next.center_z   = fit(quo[2], ovf[2], neg_d[QUO_W][2]);
    center_next.degenerate = 1'b0;
    if (deg_d[QUO_W]) begin
      center_next = '0;
      center_next.degenerate = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    center <= center_next;
  end

  `TCC_ASSERT_IMP(a_latency, start, ##LAT done, "item did not produce a result on time")
  `TCC_ASSERT_IMP(a_no_orphan, done, $past(start, LAT), "result without a matching item")
  `TCC_ASSERT_IMP(a_degen_zero, done && center.degenerate,
                  center.center_x == '0 && center.center_y == '0 && center.center_z == '0,
                  "degenerate result with non-zero centre")
  `TCC_ASSERT_NXT(a_always_ready, 1'b1, !busy && cfg_ready, "input or config port stalled")

endmodule

// ===== tb/triangle_circumcenter_3d_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle circumcentre testbench
// Streams triangles into the block under several plane normals and checks
// every centre against an exact wide-integer Cramer's rule solution kept in
// a small scoreboard, including rounding, saturation and degenerate systems.
// ----------------------------------------------------------------------------
module triangle_circumcenter_3d_top_tb;
  import tcc_pkg::*;

  typedef logic signed [255:0] wide_t;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 60;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_PER_PHASE = 290;

  class centre_scoreboard;
    center_t expected_q[$];
    norm_t   normal[3];
    int      errors;
    int      checked;

    function new();
      normal[0] = '0;
      normal[1] = '0;
      normal[2] = NORMAL_Z_RESET;
      errors = 0;
      checked = 0;
    endfunction

    function void set_normal(logic [CFG_IDX_W-1:0] idx, norm_t value);
      if (idx == CFG_NORMAL_X) normal[0] = value;
      else if (idx == CFG_NORMAL_Y) normal[1] = value;
      else if (idx == CFG_NORMAL_Z) normal[2] = value;
    endfunction

    function wide_t det3(wide_t a0, wide_t a1, wide_t a2, wide_t b0, wide_t b1,
                         wide_t b2, wide_t c0, wide_t c1, wide_t c2);
      return a0 * (b1 * c2 - b2 * c1) - a1 * (b0 * c2 - b2 * c0)
             + a2 * (b0 * c1 - b1 * c0);
    endfunction

    function coord_t rounded_quotient(wide_t num, wide_t den);
      wide_t n, d, q, lim;
      logic  neg;
      n = (num < 0) ? -num : num;
      d = (den < 0) ? -den : den;
      q = (n + d) / (d + d);
      lim = 1;
      lim = lim <<< (COORD_W - 1);
      neg = (num < 0) != (den < 0);
      if (neg) begin
        if (q > lim) return {1'b1, {(COORD_W-1){1'b0}}};
        q = -q;
      end else if (q >= lim) begin
        return {1'b0, {(COORD_W-1){1'b1}}};
      end
      return q[COORD_W-1:0];
    endfunction

    function void note(points_t p);
      wide_t ax, ay, az, bx, by, bz, cx, cy, cz, nx, ny, nz;
      wide_t m0x, m0y, m0z, m1x, m1y, m1z, r0, r1, r2, det;
      center_t c;
      ax = p.point_a_x; ay = p.point_a_y; az = p.point_a_z;
      bx = p.point_b_x; by = p.point_b_y; bz = p.point_b_z;
      cx = p.point_c_x; cy = p.point_c_y; cz = p.point_c_z;
      nx = normal[0]; ny = normal[1]; nz = normal[2];
      m0x = bx - ax; m0y = by - ay; m0z = bz - az;
      m1x = cx - ax; m1y = cy - ay; m1z = cz - az;
      r0 = (bx * bx + by * by + bz * bz) - (ax * ax + ay * ay + az * az);
      r1 = (cx * cx + cy * cy + cz * cz) - (ax * ax + ay * ay + az * az);
      r2 = 2 * (nx * bx + ny * by + nz * bz);
      det = det3(m0x, m0y, m0z, m1x, m1y, m1z, nx, ny, nz);
      c = '0;
      if (det == 0) begin
        c.degenerate = 1'b1;
      end else begin
        c.center_x = rounded_quotient(det3(r0, m0y, m0z, r1, m1y, m1z, r2, ny, nz), det);
        c.center_y = rounded_quotient(det3(m0x, r0, m0z, m1x, r1, m1z, nx, r2, nz), det);
        c.center_z = rounded_quotient(det3(m0x, m0y, r0, m1x, m1y, r1, nx, ny, r2), det);
      end
      expected_q.insert(expected_q.size(), c);
    endfunction

    task report(string what, logic signed [63:0] got, logic signed [63:0] want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      errors++;
    endtask

    task check(center_t got);
      center_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: centre arrived with no item outstanding", $time);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.center_x !== want.center_x) report("center_x", got.center_x, want.center_x);
      if (got.center_y !== want.center_y) report("center_y", got.center_y, want.center_y);
      if (got.center_z !== want.center_z) report("center_z", got.center_z, want.center_z);
      if (got.degenerate !== want.degenerate)
        report("degenerate", got.degenerate, want.degenerate);
    endtask
  endclass

  logic clk, rst, start, busy, done, cfg_valid, cfg_ready;
  points_t points;
  center_t center;
  logic [CFG_IDX_W-1:0] cfg_index;
  norm_t cfg_data;

  centre_scoreboard sb;
  int idle_cycles;
  int degenerate_seen;
  int cfg_writes;
  logic burst;

  triangle_circumcenter_3d_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .points(points),
    .done(done), .center(center), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note(points);
      if (done) begin
        if (center.degenerate) degenerate_seen++;
        sb.check(center);
      end
      if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task send_points(points_t p);
    int gap;
    start <= 1'b1;
    points <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    if ($urandom_range(0, 63) == 0) burst = !burst;
    gap = burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task send_corners(int ax, int ay, int az, int bx, int by, int bz,
                    int cx, int cy, int cz);
    points_t p;
    p.point_a_x = ax; p.point_a_y = ay; p.point_a_z = az;
    p.point_b_x = bx; p.point_b_y = by; p.point_b_z = bz;
    p.point_c_x = cx; p.point_c_y = cy; p.point_c_z = cz;
    send_points(p);
  endtask

  task drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_normal(logic [CFG_IDX_W-1:0] idx, norm_t value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_normal(idx, value);
    cfg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task set_normals(norm_t x, norm_t y, norm_t z);
    write_normal(CFG_NORMAL_X, x);
    write_normal(CFG_NORMAL_Y, y);
    write_normal(CFG_NORMAL_Z, z);
  endtask

  function coord_t random_coord(int kind);
    case (kind)
      0: return $urandom;
      1: return ($urandom_range(0, 1)) ? 32'h7fffffff : 32'h80000000;
      default: return $signed($urandom_range(0, 1 << 25)) - (1 << 24);
    endcase
  endfunction

  task send_random();
    points_t p;
    int mode, k;
    mode = $urandom_range(0, 9);
    p.point_a_x = random_coord(mode == 6 ? 0 : mode == 9 ? $urandom_range(0, 2) : 2);
    p.point_a_y = random_coord(mode == 6 ? 0 : mode == 9 ? $urandom_range(0, 2) : 2);
    p.point_a_z = random_coord(mode == 6 ? 0 : mode == 9 ? $urandom_range(0, 2) : 2);
    p.point_b_x = random_coord(mode == 6 ? 0 : mode == 9 ? $urandom_range(0, 2) : 2);
    p.point_b_y = random_coord(mode == 6 ? 0 : mode == 9 ? $urandom_range(0, 2) : 2);
    p.point_b_z = random_coord(mode == 6 ? 0 : mode == 9 ? $urandom_range(0, 2) : 2);
    p.point_c_x = random_coord(mode == 6 ? 0 : mode == 9 ? $urandom_range(0, 2) : 2);
    p.point_c_y = random_coord(mode == 6 ? 0 : mode == 9 ? $urandom_range(0, 2) : 2);
    p.point_c_z = random_coord(mode == 6 ? 0 : mode == 9 ? $urandom_range(0, 2) : 2);
    if (mode == 7) begin
      k = $signed($urandom_range(0, 6)) - 3;
      p.point_c_x = p.point_a_x + k * (p.point_b_x - p.point_a_x);
      p.point_c_y = p.point_a_y + k * (p.point_b_y - p.point_a_y);
      p.point_c_z = p.point_a_z + k * (p.point_b_z - p.point_a_z);
    end else if (mode == 8) begin
      p.point_b_x = p.point_a_x;
      p.point_b_y = p.point_a_y;
      p.point_b_z = p.point_a_z;
    end
    send_points(p);
  endtask

  task run_directed();
    int one, mx, mn;
    one = 65536;
    mx = 32'h7fffffff;
    mn = 32'h80000000;
    send_corners(0, 0, 0, 2 * one, 0, 0, 0, 2 * one, 0);
    send_corners(one, -one, 3 * one, -2 * one, 5 * one, one, 4 * one, 2 * one, -one);
    send_corners(0, 0, 0, 1, 0, 0, 0, 1, 0);
    send_corners(0, 0, 0, -1, 0, 0, 0, -1, 0);
    send_corners(0, 0, 0, one, one, one, 2 * one, 2 * one, 2 * one);
    send_corners(one, 2 * one, 3 * one, one, 2 * one, 3 * one, 0, 0, 0);
    send_corners(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_corners(0, 0, 0, 0, 0, one, one, 0, 0);
    send_corners(mx, mx, mx, mx, mx, mx, mx, mx, mx);
    send_corners(mn, mn, mn, mn, mn, mn, mn, mn, mn);
    send_corners(mx, mn, 0, mn, mx, 0, mx, mx, 0);
    send_corners(mn, mn, mn, mx, mn, mx, mn, mx, mn);
    send_corners(0, 0, 0, 1, 0, 0, 1, 1, 0);
    send_corners(0, 0, 0, 3, 0, 0, 0, 1, 0);
    send_corners(mx, 0, 0, mx, 1, 0, mx - 1, 0, 0);
    send_corners(1, 2, 0, 1, 3, 0, 100000, 2, 0);
  endtask

  task run_phase();
    repeat (RANDOM_PER_PHASE) send_random();
    drain();
  endtask

  initial begin
    sb = new();
    idle_cycles = 0;
    degenerate_seen = 0;
    cfg_writes = 0;
    burst = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    points = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_NORMAL_X;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    run_phase();

    set_normals(16'sd0, 16'sd0, 16'sd0);
    send_corners(0, 0, 0, 65536, 0, 0, 0, 65536, 0);
    run_phase();

    set_normals(16'sd32767, -16'sd32768, 16'sd32767);
    run_phase();

    set_normals(-16'sd32768, -16'sd32768, -16'sd32768);
    run_phase();

    set_normals(16'sd16384, 16'sd0, 16'sd0);
    send_corners(0, 0, 0, 65536, 0, 0, 0, 65536, 0);
    run_phase();

    set_normals(NORM_W'($urandom), NORM_W'($urandom), NORM_W'($urandom));
    write_normal(CFG_UNUSED, NORM_W'($urandom));
    run_phase();

    set_normals(NORM_W'($urandom), NORM_W'($urandom), NORM_W'($urandom));
    run_phase();

    $display("Checked %0d centres, %0d of them degenerate, across %0d register writes.",
             sb.checked, degenerate_seen, cfg_writes);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d centres never arrived.", sb.errors,
               sb.expected_q.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
